// ===== rtl/bpa_pkg.sv =====
// shared types and constants of the buddy page allocator
package bpa_pkg;

  localparam int WIDE_W = 17;
  localparam int ORD_W  = 4;
  localparam int ORD_N  = 16;

  typedef enum logic [1:0] {
    OP_ALLOC = 2'd0,
    OP_FREE  = 2'd1,
    OP_INIT  = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_NOBLK  = 2'd1,
    ST_BADORD = 2'd2,
    ST_BADREQ = 2'd3
  } stat_t;

  typedef enum logic [4:0] {
    C_NONE,
    C_LOAD,
    C_A_FIND,
    C_RM_RD,
    C_RM_WR,
    C_MERGE,
    C_SPLIT,
    C_A_FINAL,
    C_F_RD,
    C_F_START,
    C_F_LOOP,
    C_MARK_INIT,
    C_MARK,
    C_PUSH1,
    C_PUSH2,
    C_A_DONE,
    C_I_START,
    C_I_PAGE,
    C_EMIT
  } dp_op_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_A_CHECK,
    S_A_SPLIT,
    S_A_DONE,
    S_F_RD,
    S_F_CHK,
    S_F_LOOP,
    S_F_BCHK,
    S_RM_RD,
    S_RM_WR,
    S_MERGE,
    S_MARK,
    S_PUSH1,
    S_PUSH2,
    S_I_START,
    S_I_NEXT,
    S_EMIT
  } ctl_state_t;

  typedef struct packed {
    dp_op_t op;
    stat_t  stat;
  } cmd_t;

  typedef struct packed {
    logic [1:0] in_op;
    logic [1:0] op;
    logic       bad_order;
    logic       found;
    logic       free_ok;
    logic       merge_try;
    logic       buddy_free;
    logic       mark_last;
    logic       mark_alloc;
    logic       split_more;
    logic       init_more;
    logic       out_busy;
  } sts_t;

endpackage

// ===== rtl/bpa_ram.sv =====
// generic single write port ram with registered read
module bpa_ram #(
  parameter int W = 8,
  parameter int D = 16
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [$clog2(D)-1:0] waddr,
  input  logic [W-1:0]         wdata,
  input  logic [$clog2(D)-1:0] raddr,
  output logic [W-1:0]         rdata
);

  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/bpa_datapath.sv =====
// page tables, free list heads, counters and result register of the allocator
module bpa_datapath #(
  parameter int MAX_PAGES = 4096,
  parameter int MAX_ORDER = 11
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_wr_en,
  input  logic [12:0]        cfg_wr_data,
  input  logic [1:0]         in_opcode,
  input  logic [5:0]         in_req_order,
  input  logic [11:0]        in_free_page,
  input  bpa_pkg::cmd_t      cmd,
  output bpa_pkg::sts_t      sts,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         out_status,
  output logic [11:0]        out_page_index,
  output logic [3:0]         out_block_order,
  output logic [12:0]        out_free_pages
);

  localparam int AW = $clog2(MAX_PAGES);
  localparam int CW = AW + 1;
  localparam int XW = bpa_pkg::WIDE_W;
  localparam int OW = bpa_pkg::ORD_W;
  localparam int ON = bpa_pkg::ORD_N;
  localparam logic [CW-1:0] NIL = CW'(MAX_PAGES);

  logic [12:0]   pc_r;
  logic [1:0]    op_r;
  logic [5:0]    req_r;
  logic [11:0]   fp_r;
  logic [CW-1:0] pool_r;
  logic [CW-1:0] total_r;
  logic [CW-1:0] head_r [ON];
  logic [AW-1:0] p_r;
  logic [AW-1:0] b_r;
  logic [AW-1:0] blk_r;
  logic [OW-1:0] ord_r;
  logic [AW-1:0] cnt_r;
  logic          alloc_r;
  logic [CW-1:0] added_r;
  logic [CW-1:0] ip_r;
  logic          out_valid_r;
  logic [1:0]    out_status_r;
  logic [11:0]   out_page_index_r;
  logic [3:0]    out_block_order_r;
  logic [12:0]   out_free_pages_r;

  logic          meta_we;
  logic [AW-1:0] meta_waddr;
  logic [OW:0]   meta_wdata;
  logic [AW-1:0] meta_raddr;
  logic [OW:0]   meta_rd;
  logic          nxt_we;
  logic [AW-1:0] nxt_waddr;
  logic [CW-1:0] nxt_wdata;
  logic [CW-1:0] nxt_rd;
  logic          prv_we;
  logic [AW-1:0] prv_waddr;
  logic [CW-1:0] prv_wdata;
  logic [CW-1:0] prv_rd;

  logic [OW-1:0] meta_ord;
  logic          meta_alloc;
  logic [XW-1:0] fp_x;
  logic [XW-1:0] bud_x;
  logic [XW-1:0] mark_x;
  logic [XW-1:0] up_x;
  logic [CW-1:0] head_cur;
  logic [OW-1:0] m_fnd;
  logic          found;
  logic [CW-1:0] pool_n;
  logic          out_busy;
  logic          is_ok;

  bpa_ram #(.W(OW + 1), .D(MAX_PAGES)) u_meta (
    .clk(clk), .we(meta_we), .waddr(meta_waddr), .wdata(meta_wdata),
    .raddr(meta_raddr), .rdata(meta_rd)
  );

  bpa_ram #(.W(CW), .D(MAX_PAGES)) u_next (
    .clk(clk), .we(nxt_we), .waddr(nxt_waddr), .wdata(nxt_wdata),
    .raddr(b_r), .rdata(nxt_rd)
  );

  bpa_ram #(.W(CW), .D(MAX_PAGES)) u_prev (
    .clk(clk), .we(prv_we), .waddr(prv_waddr), .wdata(prv_wdata),
    .raddr(b_r), .rdata(prv_rd)
  );

  assign meta_ord   = meta_rd[OW:1];
  assign meta_alloc = meta_rd[0];
  assign fp_x       = XW'(fp_r);
  assign bud_x      = XW'(p_r) ^ (XW'(1) << ord_r);
  assign mark_x     = XW'(p_r) + XW'(cnt_r);
  assign up_x       = XW'(blk_r) + (XW'(1) << (ord_r - OW'(1)));
  assign head_cur   = head_r[ord_r];
  assign out_busy   = out_valid_r && out_stall;
  assign is_ok      = (cmd.stat == bpa_pkg::ST_OK);
  assign pool_n     = (XW'(pc_r) > XW'(MAX_PAGES)) ? NIL : CW'(pc_r);

  // lowest non-empty order at or above the request
  always_comb begin
    found = 1'b0;
    m_fnd = '0;
    for (int o = ON - 1; o >= 0; o--) begin
      if (o < MAX_ORDER && 6'(o) >= req_r && head_r[o] < NIL) begin
        found = 1'b1;
        m_fnd = OW'(o);
      end
    end
  end

  always_comb begin
    sts.in_op      = in_opcode;
    sts.op         = op_r;
    sts.bad_order  = req_r >= 6'(MAX_ORDER);
    sts.found      = found;
    sts.free_ok    = fp_x < XW'(pool_r) && meta_alloc &&
                     ((fp_x & ((XW'(1) << meta_ord) - XW'(1))) == '0);
    sts.merge_try  = (5'(ord_r) + 5'd1 < 5'(MAX_ORDER)) && bud_x < XW'(pool_r) &&
                     (op_r != bpa_pkg::OP_INIT || bud_x < XW'(p_r));
    sts.buddy_free = !meta_alloc && meta_ord == ord_r;
    sts.mark_last  = XW'(cnt_r) == (XW'(1) << ord_r) - XW'(1);
    sts.mark_alloc = alloc_r;
    sts.split_more = 6'(ord_r) > req_r;
    sts.init_more  = ip_r < pool_r;
    sts.out_busy   = out_busy;
  end

  always_comb begin
    meta_we    = 1'b0;
    meta_waddr = mark_x[AW-1:0];
    meta_wdata = {ord_r, alloc_r};
    meta_raddr = bud_x[AW-1:0];
    nxt_we     = 1'b0;
    nxt_waddr  = p_r;
    nxt_wdata  = head_cur;
    prv_we     = 1'b0;
    prv_waddr  = head_cur[AW-1:0];
    prv_wdata  = CW'(p_r);
    case (cmd.op)
      bpa_pkg::C_F_RD: begin
        meta_raddr = fp_x[AW-1:0];
      end
      bpa_pkg::C_MARK: begin
        meta_we = mark_x < XW'(MAX_PAGES);
      end
      bpa_pkg::C_RM_WR: begin
        nxt_we    = prv_rd < NIL;
        nxt_waddr = prv_rd[AW-1:0];
        nxt_wdata = nxt_rd;
        prv_we    = nxt_rd < NIL;
        prv_waddr = nxt_rd[AW-1:0];
        prv_wdata = prv_rd;
      end
      bpa_pkg::C_PUSH1: begin
        nxt_we = 1'b1;
        prv_we = head_cur < NIL;
      end
      bpa_pkg::C_PUSH2: begin
        prv_we    = 1'b1;
        prv_waddr = p_r;
        prv_wdata = NIL;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r        <= 13'd4096;
      pool_r      <= '0;
      total_r     <= '0;
      out_valid_r <= 1'b0;
      for (int o = 0; o < ON; o++) begin
        head_r[o] <= NIL;
      end
    end else begin
      if (cfg_wr_en) begin
        pc_r <= cfg_wr_data;
      end
      if (out_valid_r && !out_stall && cmd.op != bpa_pkg::C_EMIT) begin
        out_valid_r <= 1'b0;
      end
      case (cmd.op)
        bpa_pkg::C_LOAD: begin
          op_r  <= in_opcode;
          req_r <= in_req_order;
          fp_r  <= in_free_page;
        end
        bpa_pkg::C_A_FIND: begin
          ord_r <= m_fnd;
          b_r   <= head_r[m_fnd][AW-1:0];
          blk_r <= head_r[m_fnd][AW-1:0];
        end
        bpa_pkg::C_RM_WR: begin
          if (prv_rd >= NIL) begin
            head_r[ord_r] <= nxt_rd;
          end
        end
        bpa_pkg::C_MERGE: begin
          if (b_r < p_r) begin
            p_r <= b_r;
          end
          ord_r <= ord_r + OW'(1);
        end
        bpa_pkg::C_SPLIT: begin
          ord_r   <= ord_r - OW'(1);
          p_r     <= up_x[AW-1:0];
          cnt_r   <= '0;
          alloc_r <= 1'b0;
        end
        bpa_pkg::C_A_FINAL: begin
          p_r     <= blk_r;
          cnt_r   <= '0;
          alloc_r <= 1'b1;
        end
        bpa_pkg::C_F_START: begin
          p_r     <= fp_x[AW-1:0];
          ord_r   <= meta_ord;
          added_r <= CW'(1) << meta_ord;
        end
        bpa_pkg::C_F_LOOP: begin
          b_r <= bud_x[AW-1:0];
        end
        bpa_pkg::C_MARK_INIT: begin
          cnt_r   <= '0;
          alloc_r <= 1'b0;
        end
        bpa_pkg::C_MARK: begin
          cnt_r <= cnt_r + AW'(1);
        end
        bpa_pkg::C_PUSH2: begin
          head_r[ord_r] <= CW'(p_r);
          if (op_r != bpa_pkg::OP_ALLOC) begin
            total_r <= total_r + added_r;
          end
        end
        bpa_pkg::C_A_DONE: begin
          total_r <= total_r - (CW'(1) << req_r[OW-1:0]);
        end
        bpa_pkg::C_I_START: begin
          for (int o = 0; o < ON; o++) begin
            head_r[o] <= NIL;
          end
          total_r <= '0;
          pool_r  <= pool_n;
          ip_r    <= '0;
        end
        bpa_pkg::C_I_PAGE: begin
          p_r     <= ip_r[AW-1:0];
          ord_r   <= '0;
          added_r <= CW'(1);
          ip_r    <= ip_r + CW'(1);
        end
        bpa_pkg::C_EMIT: begin
          if (!out_busy) begin
            out_valid_r       <= 1'b1;
            out_status_r      <= cmd.stat;
            out_page_index_r  <= (is_ok && op_r == bpa_pkg::OP_ALLOC) ? 12'(blk_r) : '0;
            out_block_order_r <= (is_ok && op_r != bpa_pkg::OP_INIT) ? ord_r : '0;
            out_free_pages_r  <= 13'(total_r);
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_page_index  = out_page_index_r;
  assign out_block_order = out_block_order_r;
  assign out_free_pages  = out_free_pages_r;

endmodule

// ===== rtl/bpa_ctrl.sv =====
// sequencer of the allocator: walks lists, splits, merges and marks
module bpa_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  bpa_pkg::sts_t sts,
  output bpa_pkg::cmd_t cmd
);

  bpa_pkg::ctl_state_t state_r, state_nxt;
  bpa_pkg::stat_t      stat_r, stat_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bpa_pkg::S_IDLE;
      stat_r  <= bpa_pkg::ST_OK;
    end else begin
      state_r <= state_nxt;
      stat_r  <= stat_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    stat_nxt  = stat_r;
    cmd.op    = bpa_pkg::C_NONE;
    cmd.stat  = stat_r;
    in_stall  = 1'b1;
    case (state_r)
      bpa_pkg::S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.op   = bpa_pkg::C_LOAD;
          stat_nxt = bpa_pkg::ST_OK;
          case (sts.in_op)
            bpa_pkg::OP_ALLOC: state_nxt = bpa_pkg::S_A_CHECK;
            bpa_pkg::OP_FREE:  state_nxt = bpa_pkg::S_F_RD;
            bpa_pkg::OP_INIT:  state_nxt = bpa_pkg::S_I_START;
            default: begin
              stat_nxt  = bpa_pkg::ST_BADREQ;
              state_nxt = bpa_pkg::S_EMIT;
            end
          endcase
        end
      end
      bpa_pkg::S_A_CHECK: begin
        if (sts.bad_order) begin
          stat_nxt  = bpa_pkg::ST_BADORD;
          state_nxt = bpa_pkg::S_EMIT;
        end else if (!sts.found) begin
          stat_nxt  = bpa_pkg::ST_NOBLK;
          state_nxt = bpa_pkg::S_EMIT;
        end else begin
          cmd.op    = bpa_pkg::C_A_FIND;
          state_nxt = bpa_pkg::S_RM_RD;
        end
      end
      bpa_pkg::S_RM_RD: begin
        cmd.op    = bpa_pkg::C_RM_RD;
        state_nxt = bpa_pkg::S_RM_WR;
      end
      bpa_pkg::S_RM_WR: begin
        cmd.op    = bpa_pkg::C_RM_WR;
        state_nxt = (sts.op == bpa_pkg::OP_ALLOC) ? bpa_pkg::S_A_SPLIT : bpa_pkg::S_MERGE;
      end
      bpa_pkg::S_MERGE: begin
        cmd.op    = bpa_pkg::C_MERGE;
        state_nxt = bpa_pkg::S_F_LOOP;
      end
      bpa_pkg::S_A_SPLIT: begin
        cmd.op    = sts.split_more ? bpa_pkg::C_SPLIT : bpa_pkg::C_A_FINAL;
        state_nxt = bpa_pkg::S_MARK;
      end
      bpa_pkg::S_MARK: begin
        cmd.op = bpa_pkg::C_MARK;
        if (sts.mark_last) begin
          state_nxt = (sts.op == bpa_pkg::OP_ALLOC && sts.mark_alloc) ?
                      bpa_pkg::S_A_DONE : bpa_pkg::S_PUSH1;
        end
      end
      bpa_pkg::S_PUSH1: begin
        cmd.op    = bpa_pkg::C_PUSH1;
        state_nxt = bpa_pkg::S_PUSH2;
      end
      bpa_pkg::S_PUSH2: begin
        cmd.op = bpa_pkg::C_PUSH2;
        case (sts.op)
          bpa_pkg::OP_ALLOC: state_nxt = bpa_pkg::S_A_SPLIT;
          bpa_pkg::OP_INIT:  state_nxt = bpa_pkg::S_I_NEXT;
          default:           state_nxt = bpa_pkg::S_EMIT;
        endcase
      end
      bpa_pkg::S_A_DONE: begin
        cmd.op    = bpa_pkg::C_A_DONE;
        state_nxt = bpa_pkg::S_EMIT;
      end
      bpa_pkg::S_F_RD: begin
        cmd.op    = bpa_pkg::C_F_RD;
        state_nxt = bpa_pkg::S_F_CHK;
      end
      bpa_pkg::S_F_CHK: begin
        if (sts.free_ok) begin
          cmd.op    = bpa_pkg::C_F_START;
          state_nxt = bpa_pkg::S_F_LOOP;
        end else begin
          stat_nxt  = bpa_pkg::ST_BADREQ;
          state_nxt = bpa_pkg::S_EMIT;
        end
      end
      bpa_pkg::S_F_LOOP: begin
        if (sts.merge_try) begin
          cmd.op    = bpa_pkg::C_F_LOOP;
          state_nxt = bpa_pkg::S_F_BCHK;
        end else begin
          cmd.op    = bpa_pkg::C_MARK_INIT;
          state_nxt = bpa_pkg::S_MARK;
        end
      end
      bpa_pkg::S_F_BCHK: begin
        if (sts.buddy_free) begin
          state_nxt = bpa_pkg::S_RM_RD;
        end else begin
          cmd.op    = bpa_pkg::C_MARK_INIT;
          state_nxt = bpa_pkg::S_MARK;
        end
      end
      bpa_pkg::S_I_START: begin
        cmd.op    = bpa_pkg::C_I_START;
        state_nxt = bpa_pkg::S_I_NEXT;
      end
      bpa_pkg::S_I_NEXT: begin
        if (sts.init_more) begin
          cmd.op    = bpa_pkg::C_I_PAGE;
          state_nxt = bpa_pkg::S_F_LOOP;
        end else begin
          state_nxt = bpa_pkg::S_EMIT;
        end
      end
      bpa_pkg::S_EMIT: begin
        cmd.op = bpa_pkg::C_EMIT;
        if (!sts.out_busy) begin
          state_nxt = bpa_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = bpa_pkg::S_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/buddy_page_allocator.sv =====
// top level of the buddy page allocator
// One word is taken at a time; the next is accepted once the result of the last
// is in the output register. Allocate marks every page of the allocated block,
// and each split first marks every page of the upper half free and pushes it;
// free reads each buddy to see whether it is free, merges while it is, and then
// marks every page of the final block. Initialize walks every page of the pool
// as a free with merging. The page order table has a single write port, so
// pages are marked one by one.
module buddy_page_allocator #(
  parameter int MAX_PAGES = 4096,
  parameter int MAX_ORDER = 11
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [12:0] cfg_wr_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_opcode,
  input  logic [5:0]  in_req_order,
  input  logic [11:0] in_free_page,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_status,
  output logic [11:0] out_page_index,
  output logic [3:0]  out_block_order,
  output logic [12:0] out_free_pages
);

  bpa_pkg::cmd_t cmd;
  bpa_pkg::sts_t sts;

  bpa_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .sts(sts), .cmd(cmd)
  );

  bpa_datapath #(.MAX_PAGES(MAX_PAGES), .MAX_ORDER(MAX_ORDER)) u_dp (
    .clk(clk), .rst_n(rst_n),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .in_opcode(in_opcode), .in_req_order(in_req_order), .in_free_page(in_free_page),
    .cmd(cmd), .sts(sts),
    .out_valid(out_valid), .out_stall(out_stall), .out_status(out_status),
    .out_page_index(out_page_index), .out_block_order(out_block_order),
    .out_free_pages(out_free_pages)
  );

endmodule
